/* hdl/image_upload_receiver_crc_check_macros.svh */
// Assertion macros shared by the image receiver RTL.
`ifndef IMAGE_UPLOAD_RECEIVER_CRC_CHECK_MACROS_SVH
`define IMAGE_UPLOAD_RECEIVER_CRC_CHECK_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define IURCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("image receiver assertion failed");

// Next-cycle implication, checked out of reset.
`define IURCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("image receiver assertion failed");

`endif

/* hdl/iurcc_pkg.sv */
// Types, codes and the CRC-32 byte update shared by the image receiver.
package iurcc_pkg;

  // Input actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_DATA  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Result events
  localparam logic [1:0] EV_READY = 2'd0;
  localparam logic [1:0] EV_STORE = 2'd1;
  localparam logic [1:0] EV_FLASH = 2'd2;
  localparam logic [1:0] EV_ERROR = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_SIZE    = 2'd1;
  localparam logic [1:0] ERR_TIMEOUT = 2'd2;
  localparam logic [1:0] ERR_CRC     = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_IMAGE_SIZE   = 2'd0;
  localparam logic [1:0] REG_EXPECTED_CRC = 2'd1;
  localparam logic [1:0] REG_TIMEOUT      = 2'd2;

  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
  localparam logic [7:0]  PAD_BYTE      = 8'hFF;
  localparam logic [16:0] QUIET_MAX     = 17'h1_FFFF;
  localparam int          MAX_BYTES     = 65536;
  localparam int          QUEUE_DEPTH   = 4;

  // What the back end has to emit for one input item
  typedef enum logic [1:0] {
    JOB_READY,
    JOB_SIZE_ERR,
    JOB_STORE,
    JOB_TIMEOUT
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic        ends;      // store closes the upload
    logic        match;     // final CRC equals expected
    logic [1:0]  pad_cnt;   // pad bytes after the store
    logic [15:0] addr;      // address of the stored byte
    logic [15:0] pad_addr;  // address of the first pad byte
    logic [7:0]  data;
    logic [31:0] detail;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

/* hdl/iurcc_front.sv */
// Front end: configuration registers, upload state, CRC and job generation.
module iurcc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_accept,
  input  logic [1:0]        in_action,
  input  logic [7:0]        in_data_byte,
  output logic              job_push,
  output iurcc_pkg::job_t   job
);
  import iurcc_pkg::*;

  localparam logic [31:0] MAX_BYTES_W = 32'(MAX_BYTES);

  logic [16:0] image_size_r;
  logic [31:0] expected_crc_r;
  logic [15:0] timeout_r;

  logic        receiving_r, receiving_nxt;
  logic [16:0] byte_count_r, byte_count_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [16:0] quiet_r, quiet_nxt;

  logic [31:0] crc_upd;
  logic [31:0] crc_final;
  logic [16:0] count_inc;
  logic [16:0] quiet_inc;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r   <= '0;
      expected_crc_r <= '0;
      timeout_r      <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_SIZE:   image_size_r   <= cfg_data[16:0];
        REG_EXPECTED_CRC: expected_crc_r <= cfg_data;
        REG_TIMEOUT:      timeout_r      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign crc_upd   = crc_byte(crc_r, in_data_byte);
  assign crc_final = ~crc_upd;
  assign count_inc = byte_count_r + 17'd1;
  assign quiet_inc = (quiet_r < QUIET_MAX) ? quiet_r + 17'd1 : quiet_r;

  // Item classification and state update
  always_comb begin
    receiving_nxt  = receiving_r;
    byte_count_nxt = byte_count_r;
    crc_nxt        = crc_r;
    quiet_nxt      = quiet_r;
    job_push       = 1'b0;
    job            = '0;
    job.kind       = JOB_READY;
    if (in_accept) begin
      case (in_action)
        ACT_START: begin
          job_push   = 1'b1;
          job.detail = {15'd0, image_size_r};
          if (image_size_r == '0 || {15'd0, image_size_r} > MAX_BYTES_W) begin
            receiving_nxt = 1'b0;
            job.kind      = JOB_SIZE_ERR;
          end else begin
            receiving_nxt  = 1'b1;
            byte_count_nxt = '0;
            crc_nxt        = CRC_INIT;
            quiet_nxt      = '0;
            job.kind       = JOB_READY;
          end
        end
        ACT_DATA: begin
          if (receiving_r) begin
            job_push       = 1'b1;
            job.kind       = JOB_STORE;
            job.addr       = byte_count_r[15:0];
            job.data       = in_data_byte;
            job.pad_addr   = count_inc[15:0];
            job.pad_cnt    = 2'b00 - count_inc[1:0];
            job.match      = (crc_final == expected_crc_r);
            job.detail     = job.match ? {15'd0, image_size_r} : crc_final;
            crc_nxt        = crc_upd;
            byte_count_nxt = count_inc;
            quiet_nxt      = '0;
            if (count_inc >= image_size_r) begin
              job.ends      = 1'b1;
              receiving_nxt = 1'b0;
            end
          end
        end
        ACT_TICK: begin
          if (receiving_r) begin
            quiet_nxt = quiet_inc;
            if (quiet_inc > {1'b0, timeout_r}) begin
              job_push      = 1'b1;
              job.kind      = JOB_TIMEOUT;
              job.detail    = {15'd0, byte_count_r};
              receiving_nxt = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Upload state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r  <= 1'b0;
      byte_count_r <= '0;
      crc_r        <= CRC_INIT;
      quiet_r      <= '0;
    end else begin
      receiving_r  <= receiving_nxt;
      byte_count_r <= byte_count_nxt;
      crc_r        <= crc_nxt;
      quiet_r      <= quiet_nxt;
    end
  end

endmodule

/* hdl/iurcc_queue.sv */
// Small job queue between front and back end.
module iurcc_queue #(
  parameter int QDEPTH = iurcc_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  iurcc_pkg::job_t      push_job,
  input  logic                 pop,
  output iurcc_pkg::job_t      head_job,
  output iurcc_pkg::q_status_t status
);
  import iurcc_pkg::*;

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  job_t          slot_r [QDEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign status.full  = (count_r == CW'(QDEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_job     = slot_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QDEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QDEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* hdl/iurcc_back.sv */
// Back end: expands each job into result items behind an output register.
module iurcc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  iurcc_pkg::job_t      head_job,
  input  iurcc_pkg::q_status_t q_status,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_event_res,
  output logic [1:0]           out_error_code,
  output logic [15:0]          out_address,
  output logic [7:0]           out_store_data,
  output logic [31:0]          out_detail,
  output logic                 out_last
);
  import iurcc_pkg::*;

  job_t        act_r;
  logic        act_valid_r, act_valid_nxt;
  logic [2:0]  phase_r, phase_nxt;

  logic        out_valid_r;
  logic [1:0]  ev_r, err_r;
  logic [15:0] addr_r;
  logic [7:0]  data_r;
  logic [31:0] detail_r;
  logic        last_r;

  logic [1:0]  res_ev, res_err;
  logic [15:0] res_addr;
  logic [7:0]  res_data;
  logic [31:0] res_detail;
  logic        res_last;
  logic        step, act_free;

  // Result for the current phase of the active job
  always_comb begin
    res_ev     = EV_READY;
    res_err    = ERR_NONE;
    res_addr   = '0;
    res_data   = '0;
    res_detail = '0;
    res_last   = 1'b1;
    if (phase_r == 3'd0) begin
      case (act_r.kind)
        JOB_READY: begin
          res_detail = act_r.detail;
        end
        JOB_SIZE_ERR: begin
          res_ev     = EV_ERROR;
          res_err    = ERR_SIZE;
          res_detail = act_r.detail;
        end
        JOB_TIMEOUT: begin
          res_ev     = EV_ERROR;
          res_err    = ERR_TIMEOUT;
          res_detail = act_r.detail;
        end
        JOB_STORE: begin
          res_ev   = EV_STORE;
          res_addr = act_r.addr;
          res_data = act_r.data;
          res_last = !act_r.ends;
        end
        default: ;
      endcase
    end else if ({1'b0, act_r.pad_cnt} >= phase_r) begin
      // pad byte up to the word boundary
      res_ev   = EV_STORE;
      res_addr = act_r.pad_addr + 16'(phase_r - 3'd1);
      res_data = PAD_BYTE;
      res_last = 1'b0;
    end else begin
      // CRC verdict
      res_ev     = act_r.match ? EV_FLASH : EV_ERROR;
      res_err    = act_r.match ? ERR_NONE : ERR_CRC;
      res_detail = act_r.detail;
    end
  end

  assign step     = act_valid_r && (!out_valid_r || out_ready);
  assign act_free = !act_valid_r || (step && res_last);
  assign pop      = act_free && !q_status.empty;

  // Active job sequencing
  always_comb begin
    act_valid_nxt = act_valid_r;
    phase_nxt     = phase_r;
    if (act_free) begin
      act_valid_nxt = !q_status.empty;
      phase_nxt     = '0;
    end else if (step) begin
      phase_nxt = phase_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_valid_r <= 1'b0;
      phase_r     <= '0;
    end else begin
      act_valid_r <= act_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      act_r <= head_job;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      ev_r     <= res_ev;
      err_r    <= res_err;
      addr_r   <= res_addr;
      data_r   <= res_data;
      detail_r <= res_detail;
      last_r   <= res_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_res  = ev_r;
  assign out_error_code = err_r;
  assign out_address    = addr_r;
  assign out_store_data = data_r;
  assign out_detail     = detail_r;
  assign out_last       = last_r;

endmodule

/* hdl/image_upload_receiver_crc_check.sv */
// Top level of the firmware image receiver with CRC-32 check.
// Usage:
//   cfg_*  : register writes (index 0 image size, 1 expected CRC, 2 timeout
//            ticks), always ready; write only while no upload results are pending.
//   in_*   : one item per handshake: start, data byte or millisecond tick.
//   out_*  : result items, out_last marks the final result of an input item.
// An item's job is queued; the back end pops it and registers its results.
// Throughput: one input item per cycle while the job queue has room. A data
//   byte that completes the image emits up to five results (store, pads,
//   verdict), one per cycle while out_ready is high, through the back end's
//   single output register; that sequencer sets the sustained rate for such items.
// Bytes and ticks outside an upload, and action code 3, give no result.
// Reset clears the upload state, the queue and the output register; the
//   timeout register returns to 10000 ticks, the others to zero.
// When the result side stalls, the output register holds its item, the job
//   queue fills, and in_ready drops once it is full.
`include "image_upload_receiver_crc_check_macros.svh"

module image_upload_receiver_crc_check #(
  parameter int QDEPTH = iurcc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_res,
  output logic [1:0]  out_error_code,
  output logic [15:0] out_address,
  output logic [7:0]  out_store_data,
  output logic [31:0] out_detail,
  output logic        out_last
);
  import iurcc_pkg::*;

  logic      in_accept;
  logic      job_push;
  job_t      push_job;
  job_t      head_job;
  logic      pop;
  q_status_t q_status;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_status.full;
  assign in_accept = in_valid && in_ready;

  iurcc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_accept    (in_accept),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .job_push     (job_push),
    .job          (push_job)
  );

  iurcc_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  iurcc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_job       (head_job),
    .q_status       (q_status),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_res  (out_event_res),
    .out_error_code (out_error_code),
    .out_address    (out_address),
    .out_store_data (out_store_data),
    .out_detail     (out_detail),
    .out_last       (out_last)
  );

  // Checks
  `IURCC_ASSERT_IMP(a_q_sane, 1'b1, !(q_status.full && q_status.empty))
  `IURCC_ASSERT_NXT(a_start_queued, in_accept && (in_action == ACT_START), !q_status.empty)
  `IURCC_ASSERT_IMP(a_err_event, out_valid && (out_error_code != ERR_NONE), out_event_res == EV_ERROR)

endmodule

/* bench/iurcc_tb_pkg.sv */
`timescale 1ns / 100ps
// Result type, CRC-32 helper and result tracker used by the image receiver bench.
package iurcc_tb_pkg;
  import iurcc_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // One result item as seen on the out_ channel
  typedef struct packed {
    logic [1:0]  event_res;
    logic [1:0]  error_code;
    logic [15:0] address;
    logic [7:0]  store_data;
    logic [31:0] detail;
    logic        last;
  } upload_result_t;

  // Reflected CRC-32, data bits taken LSB first
  function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // Tracks upload state, predicts result items and checks them in order
  class upload_checker;
    logic [16:0]    size_limit;
    logic [31:0]    declared_crc;
    logic [15:0]    tick_limit;
    logic           uploading;
    logic [16:0]    bytes_seen;
    logic [31:0]    crc_acc;
    logic [16:0]    idle_ticks;
    upload_result_t due_results[$];
    int             errors;
    int             checked;
    int             n_ready;
    int             n_store;
    int             n_flash;
    int             n_error;

    function new();
      size_limit   = '0;
      declared_crc = '0;
      tick_limit   = TIMEOUT_RESET;
      uploading    = 1'b0;
      bytes_seen   = '0;
      crc_acc      = '1;
      idle_ticks   = '0;
      errors       = 0;
      checked      = 0;
      n_ready      = 0;
      n_store      = 0;
      n_flash      = 0;
      n_error      = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [31:0] val);
      case (idx)
        REG_IMAGE_SIZE: begin
          size_limit = val[16:0];
        end
        REG_EXPECTED_CRC: begin
          declared_crc = val;
        end
        REG_TIMEOUT: begin
          tick_limit = val[15:0];
        end
        default: begin
        end
      endcase
    endfunction

    function upload_result_t result_of(input logic [1:0] ev, input logic [1:0] err,
                                       input logic [15:0] addr, input logic [7:0] data,
                                       input logic [31:0] det);
      upload_result_t r;
      r.event_res  = ev;
      r.error_code = err;
      r.address    = addr;
      r.store_data = data;
      r.detail     = det;
      r.last       = 1'b0;
      return r;
    endfunction

    // Accepted input item: advance the upload and queue what it causes
    function void take_item(input logic [1:0] act, input logic [7:0] b);
      upload_result_t batch[$];
      logic [31:0]    final_crc;
      logic [16:0]    pad_at;
      case (act)
        ACT_START: begin
          if (size_limit == 0 || size_limit > MAX_BYTES) begin
            uploading = 1'b0;
            batch.push_back(result_of(EV_ERROR, ERR_SIZE, '0, '0, {15'd0, size_limit}));
          end else begin
            uploading  = 1'b1;
            bytes_seen = '0;
            crc_acc    = '1;
            idle_ticks = '0;
            batch.push_back(result_of(EV_READY, ERR_NONE, '0, '0, {15'd0, size_limit}));
          end
        end
        ACT_DATA: begin
          if (uploading) begin
            batch.push_back(result_of(EV_STORE, ERR_NONE, bytes_seen[15:0], b, '0));
            crc_acc    = crc32_step(crc_acc, b);
            bytes_seen = bytes_seen + 17'd1;
            idle_ticks = '0;
            // image complete: pad to a word boundary, then the verdict
            if (bytes_seen >= size_limit) begin
              final_crc = ~crc_acc;
              pad_at    = bytes_seen;
              while (pad_at[1:0] != 2'd0) begin
                batch.push_back(result_of(EV_STORE, ERR_NONE, pad_at[15:0], PAD_BYTE, '0));
                pad_at = pad_at + 17'd1;
              end
              if (final_crc == declared_crc) begin
                batch.push_back(result_of(EV_FLASH, ERR_NONE, '0, '0, {15'd0, size_limit}));
              end else begin
                batch.push_back(result_of(EV_ERROR, ERR_CRC, '0, '0, final_crc));
              end
              uploading = 1'b0;
            end
          end
        end
        ACT_TICK: begin
          if (uploading) begin
            if (idle_ticks != QUIET_MAX) begin
              idle_ticks = idle_ticks + 17'd1;
            end
            if (idle_ticks > {1'b0, tick_limit}) begin
              batch.push_back(result_of(EV_ERROR, ERR_TIMEOUT, '0, '0, {15'd0, bytes_seen}));
              uploading = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
      if (batch.size() > 0) begin
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) due_results.push_back(batch[i]);
      end
    endfunction

    // Accepted result item: compare with the oldest prediction
    function void check_result(input upload_result_t got);
      upload_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("unexpected result: ev %0d err %0d addr %h data %h detail %h last %b",
                   got.event_res, got.error_code, got.address, got.store_data,
                   got.detail, got.last);
        end
      end else begin
        want = due_results.pop_front();
        checked++;
        case (want.event_res)
          EV_READY: n_ready++;
          EV_STORE: n_store++;
          EV_FLASH: n_flash++;
          default:  n_error++;
        endcase
        if (got.event_res !== want.event_res || got.error_code !== want.error_code ||
            got.address !== want.address || got.store_data !== want.store_data ||
            got.detail !== want.detail || got.last !== want.last) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("mismatch at result %0d:", checked);
            $display("  expected ev %0d err %0d addr %h data %h detail %h last %b",
                     want.event_res, want.error_code, want.address, want.store_data,
                     want.detail, want.last);
            $display("  actual   ev %0d err %0d addr %h data %h detail %h last %b",
                     got.event_res, got.error_code, got.address, got.store_data,
                     got.detail, got.last);
          end
        end
      end
    endfunction
  endclass

endpackage

/* bench/tb_image_upload_receiver_crc_check.sv */
`timescale 1ns / 100ps
// Top of the image receiver bench: clock, reset, drivers, monitors and the test sequence.
module tb_image_upload_receiver_crc_check;
  import iurcc_pkg::*;
  import iurcc_tb_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;  // action code with no meaning
  localparam logic [1:0] REG_NONE = 2'd3;  // index with no register behind it

  localparam int RANDOM_ITEMS  = 400;
  localparam int TAIL_ITEMS    = 60;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 120;
  localparam int STALL_LIMIT   = 2000;
  localparam int END_CYCLES    = 20;
  localparam int RUN_TIMEOUT   = 40;
  localparam int LONG_TICKS    = RUN_TIMEOUT + 1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = '0;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_event_res;
  logic [1:0]  out_error_code;
  logic [15:0] out_address;
  logic [7:0]  out_store_data;
  logic [31:0] out_detail;
  logic        out_last;

  upload_checker  tracker;
  upload_result_t seen_result;
  int             sent_items = 0;
  int             input_stalls = 0;
  bit             tail = 1'b0;
  bit             pressure_req = 1'b0;
  bit             pressure_done = 1'b0;

  image_upload_receiver_crc_check i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_res  (out_event_res),
    .out_error_code (out_error_code),
    .out_address    (out_address),
    .out_store_data (out_store_data),
    .out_detail     (out_detail),
    .out_last       (out_last)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // Handshake monitors feed the tracker
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) tracker.take_item(in_action, in_data_byte);
      if (in_valid && !in_ready) input_stalls++;
      if (out_valid && out_ready) begin
        seen_result.event_res  = out_event_res;
        seen_result.error_code = out_error_code;
        seen_result.address    = out_address;
        seen_result.store_data = out_store_data;
        seen_result.detail     = out_detail;
        seen_result.last       = out_last;
        tracker.check_result(seen_result);
      end
    end
  end

  // Result side: random stalls, one long hold-off on request, none in the tail
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (pressure_req && !pressure_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        pressure_done = 1'b1;
      end else if (!tail && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run when no handshake happens for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one input item, with an optional idle burst ahead of it
  task automatic send_item(input logic [1:0] act, input logic [7:0] b);
    if (!tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, wait for every predicted result, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One upload: program the registers, start, then send up to keep bytes
  task automatic run_upload(input int size, input bit good, input logic [15:0] tmo,
                            input int tick_max, input int keep);
    logic [7:0]  img[$];
    logic [31:0] acc;
    int          k;
    acc = 32'hFFFF_FFFF;
    for (k = 0; k < size; k++) begin
      img.push_back(8'($urandom_range(0, 255)));
      acc = crc32_step(acc, img[k]);
    end
    drain_results();
    reg_write(REG_IMAGE_SIZE, size);
    reg_write(REG_EXPECTED_CRC, good ? ~acc : $urandom());
    reg_write(REG_TIMEOUT, {16'd0, tmo});
    send_item(ACT_START, 8'($urandom_range(0, 255)));
    for (k = 0; k < keep && k < size; k++) begin
      repeat ($urandom_range(0, tick_max)) send_item(ACT_TICK, 8'($urandom_range(0, 255)));
      send_item(ACT_DATA, img[k]);
    end
  endtask

  // Test sequence
  initial begin : stimulus
    int random_base;
    int phase;
    int pick;
    int size;
    int keep;
    bit good;
    tracker = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bytes, ticks and the unused action while idle are dropped
    send_item(ACT_DATA, 8'h00);
    send_item(ACT_TICK, 8'hFF);
    send_item(ACT_NONE, 8'h5A);
    // size out of range: zero, maximum field value, one above capacity
    send_item(ACT_START, 8'h00);
    drain_results();
    reg_write(REG_IMAGE_SIZE, 32'd131071);
    send_item(ACT_START, 8'hFF);
    drain_results();
    reg_write(REG_IMAGE_SIZE, MAX_BYTES + 1);
    send_item(ACT_START, 8'h0F);
    // full capacity opens, then a restart while open with a one-byte image
    drain_results();
    reg_write(REG_IMAGE_SIZE, MAX_BYTES);
    send_item(ACT_START, 8'hF0);
    drain_results();
    reg_write(REG_IMAGE_SIZE, 32'd1);
    reg_write(REG_EXPECTED_CRC, ~crc32_step(32'hFFFF_FFFF, 8'h00));
    send_item(ACT_START, 8'h00);
    send_item(ACT_DATA, 8'h00);
    // aligned image with a wrong declared CRC: no pads, mismatch
    drain_results();
    reg_write(REG_IMAGE_SIZE, 32'd4);
    reg_write(REG_EXPECTED_CRC, 32'hFFFF_FFFF);
    send_item(ACT_START, 8'hAA);
    send_item(ACT_DATA, 8'hFF);
    send_item(ACT_DATA, 8'h00);
    send_item(ACT_DATA, 8'hA5);
    send_item(ACT_DATA, 8'h5A);
    // zero timeout: the first quiet tick ends the upload
    drain_results();
    reg_write(REG_TIMEOUT, 32'd0);
    reg_write(REG_EXPECTED_CRC, 32'd0);
    reg_write(REG_IMAGE_SIZE, 32'd3);
    send_item(ACT_START, 8'h55);
    send_item(ACT_DATA, 8'h81);
    send_item(ACT_TICK, 8'h18);
    // size lowered in the middle of an upload ends it at the next byte
    drain_results();
    reg_write(REG_NONE, 32'hFFFF_FFFF);
    reg_write(REG_TIMEOUT, 32'd65535);
    reg_write(REG_IMAGE_SIZE, 32'd8);
    send_item(ACT_START, 8'h33);
    send_item(ACT_DATA, 8'h3C);
    send_item(ACT_TICK, 8'hCC);
    send_item(ACT_TICK, 8'h99);
    send_item(ACT_DATA, 8'hC3);
    drain_results();
    reg_write(REG_IMAGE_SIZE, 32'd1);
    send_item(ACT_DATA, 8'h7E);

    // random phases, mostly complete uploads
    random_base = sent_items;
    phase = 0;
    while (sent_items - random_base < RANDOM_ITEMS) begin
      phase++;
      if (sent_items - random_base >= RANDOM_ITEMS - TAIL_ITEMS) tail = 1'b1;
      size = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      good = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 19);
      if (phase == 3) begin
        // long result stall while bytes keep coming
        drain_results();
        pressure_req = 1'b1;
        run_upload(48, 1'b1, 16'hFFFF, 0, 48);
      end else if (phase == 6) begin
        // a quiet run of ticks reaches the timeout
        run_upload(2, 1'b1, 16'(RUN_TIMEOUT), 0, 1);
        repeat (LONG_TICKS) send_item(ACT_TICK, 8'($urandom_range(0, 255)));
      end else if (pick < 2) begin
        repeat ($urandom_range(1, 4)) begin
          send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      end else if (pick == 2) begin
        drain_results();
        reg_write(REG_IMAGE_SIZE,
                  ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom_range(MAX_BYTES + 1, 131071));
        send_item(ACT_START, 8'($urandom_range(0, 255)));
      end else if (pick == 3) begin
        keep = $urandom_range(1, 4);
        run_upload($urandom_range(6, 12), good, 16'($urandom_range(64, 65535)), 1, keep);
        drain_results();
        reg_write(REG_IMAGE_SIZE, $urandom_range(1, keep + 1));
        send_item(ACT_DATA, 8'($urandom_range(0, 255)));
      end else if (pick == 4) begin
        // abandoned upload, left open for the next phase
        run_upload(size, good, 16'($urandom_range(64, 65535)), 1,
                   $urandom_range(0, size - 1));
      end else if (pick < 8) begin
        run_upload(size, good, 16'($urandom_range(0, 4)), 3, size);
      end else begin
        run_upload(size, good, 16'($urandom_range(8, 65535)), $urandom_range(0, 2), size);
      end
    end

    // wind down
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    $display("Sent %0d input items over %0d phases; checked %0d results",
             sent_items, phase, tracker.checked);
    $display("(%0d ready, %0d store, %0d flash, %0d error).",
             tracker.n_ready, tracker.n_store, tracker.n_flash, tracker.n_error);
    $display("Input held off %0d cycles by result back-pressure; %0d mismatches, %0d missing.",
             input_stalls, tracker.errors, tracker.pending());
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
